@@ hdl/mrf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the CRC-16 byte step for the Modbus RTU master framer.
// No dependencies; every other file refers to it by scoped names.
package mrf_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_BAD_SLAVE = 3'd1;
   localparam logic [2:0] STAT_BAD_FUNC  = 3'd2;
   localparam logic [2:0] STAT_EXCEPTION = 3'd3;
   localparam logic [2:0] STAT_BAD_CRC   = 3'd4;
   localparam logic [2:0] STAT_TOO_SHORT = 3'd5;

   localparam logic       KIND_TX      = 1'b0;
   localparam logic       KIND_VERDICT = 1'b1;

   localparam logic       REQ_ISSUE   = 1'b0;
   localparam logic       REQ_RX_BYTE = 1'b1;

   localparam logic [7:0] FC_LONG_LO      = 8'd1;
   localparam logic [7:0] FC_LONG_HI      = 8'd6;
   localparam logic [7:0] FC_READ_COILS   = 8'd1;
   localparam logic [7:0] FC_READ_HOLDING = 8'd3;
   localparam logic [7:0] FC_READ_INPUT   = 8'd4;
   localparam logic [7:0] ONE_BYTE_COUNT  = 8'd1;

   localparam logic [2:0] LONG_LAST_DATA  = 3'd5;
   localparam logic [2:0] SHORT_LAST_DATA = 3'd1;
   localparam logic [2:0] LONG_LAST_TX    = 3'd7;
   localparam logic [2:0] SHORT_LAST_TX   = 3'd3;
   localparam logic [2:0] RX_CRC_LAST     = 3'd4;
   localparam logic [2:0] RX_CRC_LO_POS   = 3'd5;
   localparam logic [2:0] RX_CRC_HI_POS   = 3'd6;
   localparam int         MIN_FRAME       = 8;
   localparam int         WIN_DEPTH       = 7;

   typedef struct packed {
      logic        init;
      logic        step;
      logic [7:0]  data;
   } crc_ctrl_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic [2:0]  status;
      logic [7:0]  exception_code;
      logic [7:0]  data_first;
      logic [7:0]  data_second;
   } rsp_item_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ hdl/mrf_crc_unit.sv @@
`timescale 1ns / 1ps
// Shared CRC-16 accumulator: one byte folded in per step, reloaded on init.
// Depends on mrf_pkg.
module mrf_crc_unit (
   input  logic                 clock,
   input  mrf_pkg::crc_ctrl_type ctrl,
   output logic [15:0]          crc_value
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctrl.init) begin
         crc_in = mrf_pkg::CRC_INIT;
      end else if (ctrl.step) begin
         crc_in = mrf_pkg::crc16_byte(crc_ff, ctrl.data);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc_value = crc_ff;

endmodule

@@ hdl/mrf_core.sv @@
`timescale 1ns / 1ps
// Sequencer of the framer: request framing, response window, checks and verdict.
// Depends on mrf_pkg; drives the shared CRC unit and the output stage.
module mrf_core #(
   parameter int unsigned MAX_FRAME_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            slave_address,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [7:0]            req_function_code,
   input  logic [15:0]           req_address,
   input  logic [15:0]           req_request_word,
   input  logic [7:0]            req_rx_byte,
   input  logic                  req_rx_last,
   input  logic                  req_coil_mode,
   input  logic                  out_free,
   output logic                  rsp_load,
   output mrf_pkg::rsp_item_type rsp_item,
   output mrf_pkg::crc_ctrl_type crc_ctrl,
   input  logic [15:0]           crc_value
);

   localparam int CNT_CAP = (MAX_FRAME_BYTES < 127) ? MAX_FRAME_BYTES : 127;
   localparam int CNT_W   = $clog2(CNT_CAP + 1);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_RQCRC   = 6'b000010,
      S_TX      = 6'b000100,
      S_CHECK   = 6'b001000,
      S_RXCRC   = 6'b010000,
      S_VERDICT = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  func_ff, func_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] word_ff, word_in;
   logic        coil_ff, coil_in;
   logic        long_ff, long_in;
   logic [2:0]  idx_ff, idx_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  exc_ff, exc_in;
   logic        crc_chk_ff, crc_chk_in;
   logic [7:0]  win_ff [mrf_pkg::WIN_DEPTH];
   logic [7:0]  win_in [mrf_pkg::WIN_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]  held_first_ff, held_first_in;
   logic [7:0]  held_second_ff, held_second_in;

   logic        accept;
   logic [2:0]  base;
   logic [7:0]  fb;
   logic [7:0]  frame_byte;
   logic [2:0]  last_data;
   logic [2:0]  last_tx;
   logic        crc_bad;
   logic [2:0]  final_status;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign base      = coil_ff ? 3'd1 : 3'd0;
   assign fb        = win_ff[base + 3'd1];
   assign last_data = long_ff ? mrf_pkg::LONG_LAST_DATA : mrf_pkg::SHORT_LAST_DATA;
   assign last_tx   = long_ff ? mrf_pkg::LONG_LAST_TX : mrf_pkg::SHORT_LAST_TX;
   assign crc_bad   = (crc_value[7:0] != win_ff[mrf_pkg::RX_CRC_LO_POS]) ||
                      (crc_value[15:8] != win_ff[mrf_pkg::RX_CRC_HI_POS]);
   assign final_status = (crc_chk_ff && crc_bad) ? mrf_pkg::STAT_BAD_CRC : status_ff;

   always_comb begin
      frame_byte = 8'h00;
      if (long_ff) begin
         case (idx_ff)
            3'd0:    frame_byte = slave_address;
            3'd1:    frame_byte = func_ff;
            3'd2:    frame_byte = addr_ff[15:8];
            3'd3:    frame_byte = addr_ff[7:0];
            3'd4:    frame_byte = word_ff[15:8];
            3'd5:    frame_byte = word_ff[7:0];
            3'd6:    frame_byte = crc_value[7:0];
            default: frame_byte = crc_value[15:8];
         endcase
      end else begin
         case (idx_ff)
            3'd0:    frame_byte = slave_address;
            3'd1:    frame_byte = func_ff;
            3'd2:    frame_byte = crc_value[7:0];
            default: frame_byte = crc_value[15:8];
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      addr_in        = addr_ff;
      word_in        = word_ff;
      coil_in        = coil_ff;
      long_in        = long_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      exc_in         = exc_ff;
      crc_chk_in     = crc_chk_ff;
      win_in         = win_ff;
      count_in       = count_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      crc_ctrl       = '0;
      rsp_load       = 1'b0;
      rsp_item       = '0;
      rsp_item.data_first  = held_first_ff;
      rsp_item.data_second = held_second_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_function_code;
               addr_in = req_address;
               word_in = req_request_word;
               coil_in = req_coil_mode;
               idx_in  = 3'd0;
               if (req_type == mrf_pkg::REQ_ISSUE) begin
                  long_in       = (req_function_code >= mrf_pkg::FC_LONG_LO) &&
                                  (req_function_code <= mrf_pkg::FC_LONG_HI);
                  crc_ctrl.init = 1'b1;
                  state_in      = S_RQCRC;
               end else begin
                  for (int i = 0; i < mrf_pkg::WIN_DEPTH - 1; i++) begin
                     win_in[i] = win_ff[i+1];
                  end
                  win_in[mrf_pkg::WIN_DEPTH-1] = req_rx_byte;
                  if (count_ff < CNT_W'(CNT_CAP)) begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  if (req_rx_last) begin
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_RQCRC: begin
            crc_ctrl.step = 1'b1;
            crc_ctrl.data = frame_byte;
            idx_in        = idx_ff + 3'd1;
            if (idx_ff == last_data) begin
               idx_in   = 3'd0;
               state_in = S_TX;
            end
         end
         S_TX: begin
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_item.result_kind = mrf_pkg::KIND_TX;
               rsp_item.tx_byte     = frame_byte;
               rsp_item.tx_last     = (idx_ff == last_tx);
               idx_in               = idx_ff + 3'd1;
               if (idx_ff == last_tx) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CHECK: begin
            crc_chk_in = 1'b0;
            exc_in     = 8'h00;
            state_in   = S_VERDICT;
            if (count_ff < CNT_W'(mrf_pkg::MIN_FRAME)) begin
               status_in = mrf_pkg::STAT_TOO_SHORT;
            end else if (win_ff[base] != slave_address) begin
               status_in = mrf_pkg::STAT_BAD_SLAVE;
            end else if ({1'b0, fb[6:0]} != func_ff) begin
               status_in = mrf_pkg::STAT_BAD_FUNC;
            end else if (fb[7]) begin
               status_in = mrf_pkg::STAT_EXCEPTION;
               exc_in    = win_ff[base + 3'd2];
            end else begin
               status_in     = mrf_pkg::STAT_OK;
               crc_chk_in    = 1'b1;
               crc_ctrl.init = 1'b1;
               idx_in        = base;
               state_in      = S_RXCRC;
            end
         end
         S_RXCRC: begin
            crc_ctrl.step = 1'b1;
            crc_ctrl.data = win_ff[idx_ff];
            idx_in        = idx_ff + 3'd1;
            if (idx_ff == mrf_pkg::RX_CRC_LAST) begin
               state_in = S_VERDICT;
            end
         end
         S_VERDICT: begin
            if (out_free) begin
               if ((final_status == mrf_pkg::STAT_OK) &&
                   ((fb == mrf_pkg::FC_READ_COILS) || (fb == mrf_pkg::FC_READ_HOLDING) ||
                    (fb == mrf_pkg::FC_READ_INPUT))) begin
                  held_first_in = win_ff[base + 3'd3];
                  if (win_ff[base + 3'd2] != mrf_pkg::ONE_BYTE_COUNT) begin
                     held_second_in = win_ff[base + 3'd4];
                  end
               end
               rsp_load                = 1'b1;
               rsp_item.result_kind    = mrf_pkg::KIND_VERDICT;
               rsp_item.status         = final_status;
               rsp_item.exception_code = exc_ff;
               rsp_item.data_first     = held_first_in;
               rsp_item.data_second    = held_second_in;
               for (int i = 0; i < mrf_pkg::WIN_DEPTH; i++) begin
                  win_in[i] = 8'h00;
               end
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         held_first_ff  <= 8'h00;
         held_second_ff <= 8'h00;
         crc_chk_ff     <= 1'b0;
         for (int i = 0; i < mrf_pkg::WIN_DEPTH; i++) begin
            win_ff[i] <= 8'h00;
         end
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         crc_chk_ff     <= crc_chk_in;
         win_ff         <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      addr_ff   <= addr_in;
      word_ff   <= word_in;
      coil_ff   <= coil_in;
      long_ff   <= long_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      exc_ff    <= exc_in;
   end

endmodule

@@ hdl/modbus_rtu_master_framer.sv @@
`timescale 1ns / 1ps
// Top level of the Modbus RTU master framer: register port, output stage.
// Depends on mrf_pkg, mrf_crc_unit and mrf_core.
//
//   channel  | handshake            | moves
//   ---------+----------------------+-------------------------------------------
//   req_     | req_valid/req_ready  | request issue or one received byte
//   rsp_     | rsp_valid/rsp_ready  | transmit byte or response verdict
//   csr      | psel/penable/pready  | slave_address at byte address 0
//
// A request is accepted, its CRC is taken over 2 or 6 frame bytes, and then one
// byte per cycle (4 or 8) goes out while the output stage is free. A non-final
// response byte keeps req_ready high; a final one runs the checks, a CRC walk
// of up to five window bytes and the verdict. req_ready is low while busy.
// Reset is synchronous; slave_address returns to 1 and the window clears.
// A stalled rsp_ready holds the result, and the sequencer waits at its next output.
module modbus_rtu_master_framer #(
   parameter int unsigned MAX_FRAME_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_function_code,
   input  logic [15:0] req_address,
   input  logic [15:0] req_request_word,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_rx_last,
   input  logic        req_coil_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_exception_code,
   output logic [7:0]  rsp_data_first,
   output logic [7:0]  rsp_data_second,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0]            slave_ff, slave_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mrf_pkg::rsp_item_type item_ff;
   mrf_pkg::rsp_item_type core_item;
   mrf_pkg::crc_ctrl_type crc_ctrl;
   logic [15:0]           crc_value;
   logic                  out_free;
   logic                  rsp_load;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {24'h000000, slave_ff} : 32'h00000000;

   always_comb begin
      slave_in = slave_ff;
      if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         slave_in = pwdata[7:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff     <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         slave_ff     <= slave_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         item_ff <= core_item;
      end
   end

   mrf_crc_unit u_crc (
      .clock     (clock),
      .ctrl      (crc_ctrl),
      .crc_value (crc_value)
   );

   mrf_core #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .slave_address     (slave_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_function_code (req_function_code),
      .req_address       (req_address),
      .req_request_word  (req_request_word),
      .req_rx_byte       (req_rx_byte),
      .req_rx_last       (req_rx_last),
      .req_coil_mode     (req_coil_mode),
      .out_free          (out_free),
      .rsp_load          (rsp_load),
      .rsp_item          (core_item),
      .crc_ctrl          (crc_ctrl),
      .crc_value         (crc_value)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = item_ff.result_kind;
   assign rsp_tx_byte        = item_ff.tx_byte;
   assign rsp_tx_last        = item_ff.tx_last;
   assign rsp_status         = item_ff.status;
   assign rsp_exception_code = item_ff.exception_code;
   assign rsp_data_first     = item_ff.data_first;
   assign rsp_data_second    = item_ff.data_second;

endmodule

@@ hdl/mrf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the Modbus RTU master framer, bound to the top level.
// Depends on mrf_pkg and modbus_rtu_master_framer.
module mrf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_type,
   input  logic        req_rx_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_result_kind,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_tx_last,
   input  logic [2:0]  rsp_status,
   input  logic [7:0]  rsp_exception_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) &&
      $stable(rsp_status) && $stable(rsp_result_kind))
      else $error("result changed while stalled");

   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == mrf_pkg::REQ_ISSUE) |=> !req_ready)
      else $error("ready right after a request transaction");

   a_byte_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == mrf_pkg::REQ_RX_BYTE) && !req_rx_last
      |=> req_ready)
      else $error("busy after a non-final response byte");

   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == mrf_pkg::KIND_TX) |->
      (rsp_status == mrf_pkg::STAT_OK) && (rsp_exception_code == 8'h00))
      else $error("transmit result carries verdict fields");

   a_verdict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == mrf_pkg::KIND_VERDICT) |->
      !rsp_tx_last && (rsp_tx_byte == 8'h00) && (rsp_status <= mrf_pkg::STAT_TOO_SHORT))
      else $error("malformed verdict");

endmodule

bind modbus_rtu_master_framer mrf_checker u_mrf_checker (.*);
